@@ rtl/bbt_pkg.sv @@
package bbt_pkg;

  // Field widths
  localparam int DEG_W = 4;
  localparam int VAL_W = 17;
  localparam int PROD_W = 2 * VAL_W;

  // 1.0 in Q1.16
  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  // Rounding constant for Q2.32 -> Q1.16
  localparam logic [PROD_W:0] RND_HALF = 35'h0_0000_8000;

  // Command from the controller to the datapath
  typedef struct packed {
    logic             start;  // new item accepted: latch t, seed row 0
    logic             issue;  // launch one basis entry into the multiply stage
    logic [DEG_W-1:0] row;    // degree of the entry being launched
    logic [DEG_W-1:0] idx;    // index of the entry within its row
    logic             last;   // final entry of the run
  } cmd_t;

endpackage

@@ rtl/bbt_ctrl.sv @@
module bbt_ctrl #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [bbt_pkg::DEG_W-1:0] degree,
  input  logic                     adv,
  output bbt_pkg::cmd_t            cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [bbt_pkg::DEG_W-1:0] DEG_MAX = bbt_pkg::DEG_W'(MAX_DEGREE);

  logic                      state_r, state_nxt;
  logic [bbt_pkg::DEG_W-1:0] deg_r, deg_nxt;
  logic [bbt_pkg::DEG_W-1:0] row_r, row_nxt;
  logic [bbt_pkg::DEG_W-1:0] idx_r, idx_nxt;
  logic [bbt_pkg::DEG_W-1:0] deg_clamp;
  logic                      last_ent;

  assign deg_clamp = (degree > DEG_MAX) ? DEG_MAX : degree;
  assign last_ent  = (row_r == deg_r) && (idx_r == row_r);
  assign in_tready = (state_r == ST_IDLE);

  // Walk the triangle row by row, one entry per pipeline advance
  always_comb begin
    state_nxt = state_r;
    deg_nxt   = deg_r;
    row_nxt   = row_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          deg_nxt   = deg_clamp;
          row_nxt   = (deg_clamp == '0) ? '0 : bbt_pkg::DEG_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (last_ent) begin
            state_nxt = ST_IDLE;
          end else if (idx_r == row_r) begin
            row_nxt = row_r + bbt_pkg::DEG_W'(1);
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + bbt_pkg::DEG_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.start = (state_r == ST_IDLE) && in_tvalid;
    cmd.issue = (state_r == ST_RUN) && adv;
    cmd.row   = row_r;
    cmd.idx   = idx_r;
    cmd.last  = last_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      deg_r   <= '0;
      row_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      deg_r   <= deg_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  // Counters never leave the triangle
  a_idx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (idx_r <= row_r) && (row_r <= deg_r))
    else $error("entry index outside its row");

  // An accepted beat always starts a run at index zero
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_RUN) && (idx_r == '0))
    else $error("run did not start after accept");
`endif

endmodule

@@ rtl/bbt_dp.sv @@
module bbt_dp #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bbt_pkg::cmd_t             cmd,
  input  logic [bbt_pkg::VAL_W-1:0] in_t,
  output logic                      adv,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [bbt_pkg::DEG_W-1:0] out_row,
  output logic [bbt_pkg::DEG_W-1:0] out_idx,
  output logic [bbt_pkg::VAL_W-1:0] out_val,
  output logic                      out_last
);

  localparam int IW = $clog2(MAX_DEGREE + 1);
  localparam int VW = bbt_pkg::VAL_W;
  localparam int PW = bbt_pkg::PROD_W;

  // Previous basis row, updated in place
  logic [VW-1:0] prev_r [0:MAX_DEGREE];

  logic [VW-1:0] t_r;
  logic [VW-1:0] t_clamp;
  logic [VW-1:0] u_val;
  logic [VW-1:0] carry_r;
  logic [VW-1:0] rd_val;
  logic [VW-1:0] opa, opb, fac_b;

  // Multiply stage
  logic                      s1_v_r;
  logic [bbt_pkg::DEG_W-1:0] s1_row_r, s1_idx_r;
  logic                      s1_last_r;
  logic [PW-1:0]             prod_a_r, prod_b_r;

  // Sum, round and saturate
  logic [PW:0]   sum;
  logic [PW:0]   rnd;
  logic [PW-16:0] q;
  logic [VW-1:0] s1_val;

  // Output register
  logic                      out_v_r;
  logic [bbt_pkg::DEG_W-1:0] out_row_r, out_idx_r;
  logic [VW-1:0]             out_val_r;
  logic                      out_last_r;

  assign adv     = !out_v_r || out_tready;
  assign t_clamp = (in_t > bbt_pkg::ONE_Q16) ? bbt_pkg::ONE_Q16 : in_t;
  assign u_val   = bbt_pkg::ONE_Q16 - t_r;
  assign rd_val  = prev_r[cmd.idx[IW-1:0]];

  // Operand select: no left neighbor at index 0, no right neighbor at the row end.
  // Row 0 scales the seeded 1.0 by 1.0.
  always_comb begin
    opa   = (cmd.idx == '0) ? '0 : carry_r;
    opb   = ((cmd.idx == cmd.row) && (cmd.row != '0)) ? '0 : rd_val;
    fac_b = (cmd.row == '0) ? bbt_pkg::ONE_Q16 : u_val;
  end

  assign sum    = (PW+1)'(prod_a_r) + (PW+1)'(prod_b_r);
  assign rnd    = sum + bbt_pkg::RND_HALF;
  assign q      = rnd[PW:16];
  assign s1_val = (q > (PW-15)'(bbt_pkg::ONE_Q16)) ? bbt_pkg::ONE_Q16 : q[VW-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.start) t_r <= t_clamp;
      if (adv) begin
        s1_v_r  <= cmd.issue;
        out_v_r <= s1_v_r;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (cmd.issue) begin
        s1_row_r  <= cmd.row;
        s1_idx_r  <= cmd.idx;
        s1_last_r <= cmd.last;
        prod_a_r  <= PW'(t_r) * PW'(opa);
        prod_b_r  <= PW'(fac_b) * PW'(opb);
        carry_r   <= rd_val;
      end
      out_row_r  <= s1_row_r;
      out_idx_r  <= s1_idx_r;
      out_val_r  <= s1_val;
      out_last_r <= s1_last_r;
    end
  end

  // Row store: entry written as it leaves the multiply stage; row 0 seeded at start
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) prev_r[s1_idx_r[IW-1:0]] <= s1_val;
    if (cmd.start) prev_r[0] <= bbt_pkg::ONE_Q16;
  end

  assign out_tvalid = out_v_r;
  assign out_row    = out_row_r;
  assign out_idx    = out_idx_r;
  assign out_val    = out_val_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_val_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_val_r <= bbt_pkg::ONE_Q16))
    else $error("basis value above 1.0");

  a_idx_le_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_idx_r <= out_row_r))
    else $error("basis index beyond row degree");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_last_r) |-> (out_idx_r == out_row_r))
    else $error("last beat not at end of its row");
`endif

endmodule

@@ rtl/bernstein_basis_triangle.sv @@
// Bernstein basis triangle: each input beat carries t in Q1.16 (values above 1.0 are
// taken as 1.0); the block emits the basis rows of degree 1 up to the programmed
// degree d (clamped to MAX_DEGREE), lowest degree first and lowest index first
// within a row, one value per output beat, with tlast on the final one. Degree 0
// emits a single 1.0. Values come from the de Casteljau recurrence, rounded to
// nearest and saturated at 1.0. An item with d >= 1 produces d*(d+3)/2 beats: the
// block first accepts the item, then sends one entry per cycle through the shared
// pair of 17x17 multipliers. The next item is taken once the last entry of the
// current one has entered the multiply stage; output backpressure stalls the whole
// pipeline. Register 0 (byte address 0) holds the degree, reset value 3.
module bernstein_basis_triangle #(
  parameter int MAX_DEGREE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] param_t
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] row_degree, [7:4] basis_index, [24:8] basis_value
  output logic        out_tlast,  // last_of_run
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_DEGREE = 1'b0;

  logic [bbt_pkg::DEG_W-1:0] degree_r;
  logic                      cfg_wr;
  bbt_pkg::cmd_t             cmd;
  logic                      adv;
  logic [bbt_pkg::DEG_W-1:0] out_row, out_idx;
  logic [bbt_pkg::VAL_W-1:0] out_val;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= bbt_pkg::DEG_W'(3);
    end else if (cfg_wr && (cfg_paddr[2] == REG_DEGREE)) begin
      degree_r <= cfg_pwdata[bbt_pkg::DEG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DEGREE) ? {28'b0, degree_r} : 32'b0;

  bbt_ctrl #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .degree    (degree_r),
    .adv       (adv),
    .cmd       (cmd)
  );

  bbt_dp #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_t       (in_tdata[16:0]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (out_row),
    .out_idx    (out_idx),
    .out_val    (out_val),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'b0, out_val, out_idx, out_row};

endmodule
